// ===== rtl/djss_pkg.sv =====
// ============================================================================
// djss_pkg
// Shared types and constants for the damped Jacobi five-point stencil sweep.
// ============================================================================
package djss_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int IDX_W  = 11;
  localparam int REG_IDX_W = 1;

  // Default line buffer capacity (intervals per side)
  localparam int MAX_INTERVALS_DEF = 1024;

  // Register reset values
  localparam logic [IDX_W-1:0]  GRID_RESET = 11'd8;
  localparam logic [DATA_W-1:0] H2_RESET   = 32'd67108864;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_GRID_INTERVALS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_H_SQUARED      = 1'd1;

  // floor(2^32 / 6), unsigned Q0.32
  localparam logic [29:0] RECIP_SIX = 30'd715827882;

  // Per-request result flags
  typedef struct packed {
    logic emit_a;    // result for the point one row above
    logic interior;  // that point is interior: run the stencil
    logic emit_b;    // extra zero result for the last row's own point
    logic last_b;    // extra result closes the sweep when its row also ends
  } djss_flags_t;

  // Pipeline control carried beside the data
  typedef struct packed {
    logic        valid;
    djss_flags_t flags;
  } djss_ctl_t;

  // Stencil window after the line buffer read
  typedef struct packed {
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] down;
    logic [DATA_W-1:0] rhs;
  } djss_win_t;

  // Final operands: center value and signed correction magnitude
  typedef struct packed {
    logic [DATA_W-1:0] c;
    logic [33:0]       m;
    logic              neg;
  } djss_fin_t;

endpackage

// ===== rtl/damped_jacobi_stencil_sweep.sv =====
// ============================================================================
// damped_jacobi_stencil_sweep
// One weighted Jacobi sweep (omega 2/3) of the 2D five-point Poisson stencil.
// ============================================================================
// Usage:
//   Grid points enter on the in_ channel in raster order, each as a Q16.16
//   current value and right-hand side. A request for point (i,j) yields the
//   new value of point (i-1,j); row zero yields nothing, and every request of
//   the last row yields two results, the second being that row's own point
//   (zero), with out_last_point set on the final point of the sweep. Boundary
//   points give zero. After the final point the indices wrap for a new sweep.
//   cfg_ writes set grid_intervals and h_squared; write them only while idle.
// Timing:
//   A request passes one line-buffer read stage, six arithmetic stages and
//   the output register.
//   Throughput is one request per cycle while out_ready is high; on the last
//   row the single output register holds the pipeline to emit both results.
// Reset and stalls:
//   Synchronous reset clears the raster position and all valid bits; the
//   line buffers are not cleared. The pipeline advances as one: it holds, and
//   in_ready drops, while the output register keeps a result that cannot
//   leave this cycle (out_ready low, or the first of a last-row pair).
// ============================================================================
module damped_jacobi_stencil_sweep import djss_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_u_value,
  input  logic signed [31:0]   in_rhs_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_new_value,
  output logic                 out_last_point,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic [IDX_W-1:0]  grid_r;
  logic [DATA_W-1:0] h2_r;
  logic              adv;
  djss_ctl_t         s1_ctl, s7_ctl;
  djss_win_t         s1_data;
  djss_fin_t         s7_fin;
  logic [DATA_W-1:0] new_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_RESET;
      h2_r   <= H2_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_INTERVALS: grid_r <= cfg_data[IDX_W-1:0];
        REG_H_SQUARED:      h2_r   <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign in_ready = adv;

  djss_window #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_u_value     (in_u_value),
    .in_rhs_value   (in_rhs_value),
    .grid_intervals (grid_r),
    .s1_ctl         (s1_ctl),
    .s1_data        (s1_data)
  );

  djss_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .h_squared (h2_r),
    .s1_ctl    (s1_ctl),
    .s1_data   (s1_data),
    .s7_ctl    (s7_ctl),
    .s7_fin    (s7_fin)
  );

  djss_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .s7_ctl         (s7_ctl),
    .s7_fin         (s7_fin),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_new_value  (new_value),
    .out_last_point (out_last_point),
    .adv            (adv)
  );

  assign out_new_value = $signed(new_value);

endmodule

// ===== rtl/djss_window.sv =====
// ============================================================================
// djss_window
// Raster index tracking, line buffers for values and right-hand sides, and
// the registered stencil window (first pipeline stage).
// ============================================================================
module djss_window import djss_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [DATA_W-1:0] in_u_value,
  input  logic [DATA_W-1:0] in_rhs_value,
  input  logic [IDX_W-1:0]  grid_intervals,
  output djss_ctl_t         s1_ctl,
  output djss_win_t         s1_data
);

  localparam int ROW_LEN = MAX_INTERVALS + 1;
  localparam int AW      = $clog2(ROW_LEN);
  localparam logic [31:0] MAX_U = 32'(MAX_INTERVALS);

  // Line buffers: even rows, odd rows, right-hand sides of the previous row
  logic [DATA_W-1:0] even_mem [ROW_LEN];
  logic [DATA_W-1:0] odd_mem  [ROW_LEN];
  logic [DATA_W-1:0] rhs_mem  [ROW_LEN];

  logic [IDX_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [IDX_W-1:0]  n_eff, j_cl;
  logic [31:0]       grid_ext, n_ext, col_ext, j_ext;
  logic [AW-1:0]     addr_a, addr_b;
  logic              acc, cur;
  djss_flags_t       flags_nxt;
  djss_ctl_t         ctl_r;

  logic [DATA_W-1:0] even_qa_r, even_qb_r, odd_qa_r, odd_qb_r, rhs_q_r;
  logic [DATA_W-1:0] down_r, left_r;
  logic [DATA_W-1:0] up_sel, c_sel, right_sel;
  logic              cur_r;

  assign acc = in_valid & adv;
  assign cur = row_r[0];

  // Clamp the grid size and column, form addresses and result flags
  always_comb begin
    grid_ext = 32'(grid_intervals);
    if (grid_ext < 32'd2) begin
      n_ext = 32'd2;
    end else if (grid_ext > MAX_U) begin
      n_ext = MAX_U;
    end else begin
      n_ext = grid_ext;
    end
    n_eff = n_ext[IDX_W-1:0];

    col_ext = 32'(col_r);
    j_ext   = (col_ext > MAX_U) ? MAX_U : col_ext;
    j_cl    = j_ext[IDX_W-1:0];

    addr_a = AW'(j_ext);
    addr_b = (j_ext < MAX_U) ? AW'(j_ext + 32'd1) : AW'(j_ext);

    flags_nxt.emit_a   = (row_r != '0);
    flags_nxt.interior = (row_r >= IDX_W'(2)) && (j_cl != '0) && (j_cl < n_eff);
    flags_nxt.emit_b   = (row_r >= n_eff);
    flags_nxt.last_b   = (j_cl >= n_eff);

    if (j_cl >= n_eff) begin
      col_nxt = '0;
      row_nxt = (row_r >= n_eff) ? '0 : row_r + IDX_W'(1);
    end else begin
      col_nxt = j_cl + IDX_W'(1);
      row_nxt = row_r;
    end
  end

  // Advance the raster position and the stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ctl_r <= '0;
    end else begin
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (adv) begin
        ctl_r.valid <= in_valid;
        ctl_r.flags <= flags_nxt;
      end
    end
  end

  // Read the window (old contents), then store the new point
  always_ff @(posedge clk) begin
    if (acc) begin
      if (cur) begin
        odd_mem[addr_a] <= in_u_value;
      end else begin
        even_mem[addr_a] <= in_u_value;
      end
      rhs_mem[addr_a] <= in_rhs_value;
      even_qa_r <= even_mem[addr_a];
      even_qb_r <= even_mem[addr_b];
      odd_qa_r  <= odd_mem[addr_a];
      odd_qb_r  <= odd_mem[addr_b];
      rhs_q_r   <= rhs_mem[addr_a];
    end
  end

  // Hold the previous center as the left neighbor
  always_ff @(posedge clk) begin
    if (acc) begin
      left_r <= c_sel;
      down_r <= in_u_value;
      cur_r  <= cur;
    end
  end

  // Pick rows by parity of the arriving row
  always_comb begin
    up_sel    = cur_r ? odd_qa_r  : even_qa_r;
    c_sel     = cur_r ? even_qa_r : odd_qa_r;
    right_sel = cur_r ? even_qb_r : odd_qb_r;
  end

  assign s1_ctl        = ctl_r;
  assign s1_data.up    = up_sel;
  assign s1_data.left  = left_r;
  assign s1_data.c     = c_sel;
  assign s1_data.right = right_sel;
  assign s1_data.down  = down_r;
  assign s1_data.rhs   = rhs_q_r;

endmodule

// ===== rtl/djss_arith.sv =====
// ============================================================================
// djss_arith
// Stencil arithmetic pipeline: h^2 scaling, neighbor sum, divide by six
// through the Q0.32 reciprocal, split over six register stages.
// ============================================================================
module djss_arith import djss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [DATA_W-1:0] h_squared,
  input  djss_ctl_t         s1_ctl,
  input  djss_win_t         s1_data,
  output djss_ctl_t         s7_ctl,
  output djss_fin_t         s7_fin
);

  djss_ctl_t ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;

  logic signed [64:0] p_full;
  logic [63:0]        p2_r;
  logic [32:0]        s1_2_r;
  logic [34:0]        s2_2_r;
  logic [DATA_W-1:0]  c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  logic [31:0] t_nxt, t3_r;
  logic [35:0] s3_r;
  logic [35:0] d4_r;
  logic [34:0] a5_r;
  logic        neg5_r, neg6_r, neg7_r;
  logic [61:0] lo_prod;
  logic [32:0] hir6_r;
  logic [29:0] lohi6_r;
  logic [33:0] m7_r;

  // Valid and flags travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else if (adv) begin
      ctl2_r <= s1_ctl;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  // Signed rhs times unsigned h^2, exact
  assign p_full = $signed(s1_data.rhs) * $signed({1'b0, h_squared});

  // Truncate the product toward zero
  assign t_nxt = p2_r[63:32] + {31'd0, p2_r[63] & (|p2_r[31:0])};

  // Reciprocal product of the low word
  assign lo_prod = 62'(a5_r[31:0]) * 62'(RECIP_SIX);

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 2: h^2 product, partial neighbor sums
      p2_r   <= p_full[63:0];
      s1_2_r <= {s1_data.up[31], s1_data.up} + {s1_data.down[31], s1_data.down};
      s2_2_r <= {{3{s1_data.left[31]}}, s1_data.left}
              + {{3{s1_data.right[31]}}, s1_data.right}
              - {s1_data.c[31], s1_data.c, 2'b00};
      c2_r   <= s1_data.c;

      // Stage 3: scaled rhs, combined neighbor sum
      t3_r <= t_nxt;
      s3_r <= {{3{s1_2_r[32]}}, s1_2_r} + {s2_2_r[34], s2_2_r};
      c3_r <= c2_r;

      // Stage 4: full residual
      d4_r <= {{4{t3_r[31]}}, t3_r} + s3_r;
      c4_r <= c3_r;

      // Stage 5: magnitude and sign
      neg5_r <= d4_r[35];
      a5_r   <= d4_r[35] ? 35'(-d4_r) : d4_r[34:0];
      c5_r   <= c4_r;

      // Stage 6: multiply by the reciprocal of six
      hir6_r  <= 33'(a5_r[34:32]) * 33'(RECIP_SIX);
      lohi6_r <= lo_prod[61:32];
      neg6_r  <= neg5_r;
      c6_r    <= c5_r;

      // Stage 7: correction magnitude
      m7_r   <= 34'(hir6_r) + 34'(lohi6_r);
      neg7_r <= neg6_r;
      c7_r   <= c6_r;
    end
  end

  assign s7_ctl     = ctl7_r;
  assign s7_fin.c   = c7_r;
  assign s7_fin.m   = m7_r;
  assign s7_fin.neg = neg7_r;

endmodule

// ===== rtl/djss_out.sv =====
// ============================================================================
// djss_out
// Output register: final add with saturation, and the split of one request
// into up to two results on the last row. Drives the pipeline advance.
// ============================================================================
module djss_out import djss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  djss_ctl_t         s7_ctl,
  input  djss_fin_t         s7_fin,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_new_value,
  output logic              out_last_point,
  output logic              adv
);

  logic              o_v_r, o_a_r, o_b_r, o_last_r;
  logic [DATA_W-1:0] o_val_r;
  logic [35:0]       res;
  logic [DATA_W-1:0] sat_val;
  logic              leaving;

  // Center plus or minus the correction, clipped to 32 bits
  always_comb begin
    if (s7_fin.neg) begin
      res = {{4{s7_fin.c[31]}}, s7_fin.c} - {2'b00, s7_fin.m};
    end else begin
      res = {{4{s7_fin.c[31]}}, s7_fin.c} + {2'b00, s7_fin.m};
    end
    if (!res[35] && (|res[34:31])) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (res[35] && !(&res[34:31])) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = res[31:0];
    end
  end

  // The register frees up once its last pending result is taken
  assign leaving = o_v_r & out_ready & ~(o_a_r & o_b_r);
  assign adv     = ~o_v_r | leaving;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      o_a_r <= 1'b0;
      o_b_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= s7_ctl.valid & (s7_ctl.flags.emit_a | s7_ctl.flags.emit_b);
      o_a_r <= s7_ctl.flags.emit_a;
      o_b_r <= s7_ctl.flags.emit_b;
    end else if (o_v_r & out_ready) begin
      // First of two results taken: drop to the second
      o_a_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_last_r <= s7_ctl.flags.last_b;
      o_val_r  <= s7_ctl.flags.interior ? sat_val : '0;
    end
  end

  assign out_valid      = o_v_r;
  assign out_new_value  = o_a_r ? o_val_r : '0;
  assign out_last_point = ~o_a_r & o_last_r;

endmodule
